// File: sv/lpg_pkg.sv
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and codes of the line point generator: request and response
// words, per-axis walk state, operation and step direction codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lpg_pkg;

   localparam int CoordBits = 12;
   localparam int ColorBits = 16;
   localparam int ErrBits   = CoordBits + 1;

   typedef logic [CoordBits-1:0] coord_type;
   typedef logic [ErrBits-1:0]   err_type;
   typedef logic [ColorBits-1:0] color_type;
   typedef logic [1:0]           dir_type;

   localparam logic OpStart = 1'b0;
   localparam logic OpNext  = 1'b1;

   localparam dir_type DirNone  = 2'd0;
   localparam dir_type DirPlus  = 2'd1;
   localparam dir_type DirMinus = 2'd3;

   typedef struct packed {
      logic      op;
      coord_type x_start;
      coord_type y_start;
      coord_type x_end;
      coord_type y_end;
      color_type pixel_color;
   } req_type;

   typedef struct packed {
      coord_type point_x;
      coord_type point_y;
      color_type point_color;
      logic      last_point;
   } rsp_type;

   typedef struct packed {
      coord_type coord;
      err_type   err;
      coord_type delta;
      dir_type   dir;
   } axis_type;

endpackage

`default_nettype wire

// File: sv/line_point_generator_unit.sv
// ----------------------------------------------------------------------------
// line_point_generator_unit
// Raster line point generator with an error-accumulator walk.
// ----------------------------------------------------------------------------
// A start word (op = start) loads both end points and the color and gives no
// response. Each next word while a line is active gives one response word
// with a point, its color and a flag on the end point. A line of major
// length L gives L + 2 points; the first point comes twice. A next word with
// no active line is taken and dropped. A start word while a line is active
// drops the old line.
// A point is registered and leaves on rsp in the cycle after its next word is taken.
// Throughput: one word per cycle on req while req_stall is low, set by the single
// response register; the walk itself finishes a step in that same cycle.
// req_stall rises only while the response register holds a word that the
// receiver stalls; the block then holds all state until the word is taken.
// Reset clears the active line and the response valid.
// ----------------------------------------------------------------------------
`default_nettype none

module line_point_generator_unit (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  lpg_pkg::req_type req_word,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output lpg_pkg::rsp_type rsp_word
);

   lpg_pkg::axis_type  axis_x_ff, axis_x_in, axis_x_step;
   lpg_pkg::axis_type  axis_y_ff, axis_y_in, axis_y_step;
   lpg_pkg::axis_type  setup_x, setup_y;
   lpg_pkg::coord_type major_ff, major_in, setup_major;
   lpg_pkg::err_type   left_ff, left_in;
   lpg_pkg::color_type color_ff, color_in;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   lpg_pkg::rsp_type   rsp_word_ff, rsp_word_in;
   logic               accept, do_start, do_emit, is_last;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign do_start  = accept & (req_word.op == lpg_pkg::OpStart);
   assign do_emit   = accept & (req_word.op == lpg_pkg::OpNext) & busy_ff;
   assign is_last   = left_ff <= lpg_pkg::ErrBits'(1);

   always_comb begin
      setup_x.coord = req_word.x_start;
      setup_x.err   = '0;
      if (req_word.x_end > req_word.x_start) begin
         setup_x.delta = req_word.x_end - req_word.x_start;
         setup_x.dir   = lpg_pkg::DirPlus;
      end else if (req_word.x_end == req_word.x_start) begin
         setup_x.delta = '0;
         setup_x.dir   = lpg_pkg::DirNone;
      end else begin
         setup_x.delta = req_word.x_start - req_word.x_end;
         setup_x.dir   = lpg_pkg::DirMinus;
      end
      setup_y.coord = req_word.y_start;
      setup_y.err   = '0;
      if (req_word.y_end > req_word.y_start) begin
         setup_y.delta = req_word.y_end - req_word.y_start;
         setup_y.dir   = lpg_pkg::DirPlus;
      end else if (req_word.y_end == req_word.y_start) begin
         setup_y.delta = '0;
         setup_y.dir   = lpg_pkg::DirNone;
      end else begin
         setup_y.delta = req_word.y_start - req_word.y_end;
         setup_y.dir   = lpg_pkg::DirMinus;
      end
      setup_major = (setup_x.delta > setup_y.delta) ? setup_x.delta : setup_y.delta;
   end

   lpg_axis u_axis_x (
      .cur_axis (axis_x_ff),
      .major    (major_ff),
      .nxt_axis (axis_x_step)
   );

   lpg_axis u_axis_y (
      .cur_axis (axis_y_ff),
      .major    (major_ff),
      .nxt_axis (axis_y_step)
   );

   always_comb begin
      axis_x_in    = axis_x_ff;
      axis_y_in    = axis_y_ff;
      major_in     = major_ff;
      left_in      = left_ff;
      color_in     = color_ff;
      busy_in      = busy_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (do_start) begin
         axis_x_in = setup_x;
         axis_y_in = setup_y;
         major_in  = setup_major;
         left_in   = {1'b0, setup_major} + lpg_pkg::ErrBits'(2);
         color_in  = req_word.pixel_color;
         busy_in   = 1'b1;
      end else if (do_emit) begin
         rsp_valid_in            = 1'b1;
         rsp_word_in.point_x     = axis_x_ff.coord;
         rsp_word_in.point_y     = axis_y_ff.coord;
         rsp_word_in.point_color = color_ff;
         rsp_word_in.last_point  = is_last;
         if (is_last) begin
            left_in = '0;
            busy_in = 1'b0;
         end else begin
            left_in   = left_ff - lpg_pkg::ErrBits'(1);
            axis_x_in = axis_x_step;
            axis_y_in = axis_y_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         left_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         left_ff      <= left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      axis_x_ff   <= axis_x_in;
      axis_y_ff   <= axis_y_in;
      major_ff    <= major_in;
      color_ff    <= color_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff == (left_ff != '0))
      else $error("busy flag and point count disagree");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      do_emit && is_last |=> !busy_ff)
      else $error("line still active after its end point");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      do_start |=> busy_ff)
      else $error("start word did not open a line");

   a_err_x: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> axis_x_ff.err <= {1'b0, major_ff})
      else $error("x error above major length");

   a_err_y: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> axis_y_ff.err <= {1'b0, major_ff})
      else $error("y error above major length");

endmodule

`default_nettype wire

// File: sv/lpg_axis.sv
// ----------------------------------------------------------------------------
// lpg_axis
// One axis of the error-accumulator walk: add the delta to the error and,
// when the error passes the major length, take the length off and step.
// ----------------------------------------------------------------------------
`default_nettype none

module lpg_axis (
   input  lpg_pkg::axis_type  cur_axis,
   input  lpg_pkg::coord_type major,
   output lpg_pkg::axis_type  nxt_axis
);

   lpg_pkg::err_type   sum;
   logic               step;
   lpg_pkg::coord_type moved;

   assign sum  = cur_axis.err + {1'b0, cur_axis.delta};
   assign step = sum > {1'b0, major};

   always_comb begin
      case (cur_axis.dir)
         lpg_pkg::DirPlus:  moved = cur_axis.coord + lpg_pkg::CoordBits'(1);
         lpg_pkg::DirMinus: moved = cur_axis.coord - lpg_pkg::CoordBits'(1);
         default:           moved = cur_axis.coord;
      endcase
   end

   always_comb begin
      nxt_axis       = cur_axis;
      nxt_axis.err   = step ? sum - {1'b0, major} : sum;
      nxt_axis.coord = step ? moved : cur_axis.coord;
   end

endmodule

`default_nettype wire

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for line_point_generator_unit.
// ----------------------------------------------------------------------------
// Drives start and next words on req and walks each line in a behavioral
// error-accumulator model, queuing one expected point per next word taken on
// an active line. Every point taken on rsp is compared field by field with
// the oldest queued point. Directed lines cover next with no active line,
// zero-length lines, steps away from the coordinate extremes, restart on an
// active line and the first points of a full-span line. Random lines follow,
// in phases with no idling, with sender gaps, with receiver stalls and with
// both at once.
// ----------------------------------------------------------------------------

module testbench;

   localparam int MaxCoord = (1 << lpg_pkg::CoordBits) - 1;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   lpg_pkg::req_type req_word  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   lpg_pkg::rsp_type rsp_word;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int words_sent         = 0;
   int lines_started      = 0;
   int points_checked     = 0;
   int failures           = 0;

   lpg_pkg::rsp_type expected_points[$];

   // model of the line walk
   lpg_pkg::coord_type walk_x      = '0;
   lpg_pkg::coord_type walk_y      = '0;
   int                 walk_err_x  = 0;
   int                 walk_err_y  = 0;
   int                 walk_dx     = 0;
   int                 walk_dy     = 0;
   int                 walk_major  = 0;
   lpg_pkg::dir_type   walk_dir_x  = lpg_pkg::DirNone;
   lpg_pkg::dir_type   walk_dir_y  = lpg_pkg::DirNone;
   int                 walk_left   = 0;
   lpg_pkg::color_type walk_color  = '0;
   bit                 walk_busy   = 1'b0;

   line_point_generator_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic measure_axis(input lpg_pkg::coord_type from_c,
                               input lpg_pkg::coord_type to_c,
                               output int delta, output lpg_pkg::dir_type dir);
      if (to_c > from_c) begin
         delta = int'(to_c) - int'(from_c);
         dir   = lpg_pkg::DirPlus;
      end else if (to_c == from_c) begin
         delta = 0;
         dir   = lpg_pkg::DirNone;
      end else begin
         delta = int'(from_c) - int'(to_c);
         dir   = lpg_pkg::DirMinus;
      end
   endtask

   function automatic lpg_pkg::coord_type step_coord(input lpg_pkg::coord_type c,
                                                     input lpg_pkg::dir_type dir);
      case (dir)
         lpg_pkg::DirPlus:  return c + 1'b1;
         lpg_pkg::DirMinus: return c - 1'b1;
         default:           return c;
      endcase
   endfunction

   task automatic predict_word(input lpg_pkg::req_type w);
      lpg_pkg::rsp_type point;
      if (w.op == lpg_pkg::OpStart) begin
         measure_axis(w.x_start, w.x_end, walk_dx, walk_dir_x);
         measure_axis(w.y_start, w.y_end, walk_dy, walk_dir_y);
         walk_major = (walk_dx > walk_dy) ? walk_dx : walk_dy;
         walk_x     = w.x_start;
         walk_y     = w.y_start;
         walk_err_x = 0;
         walk_err_y = 0;
         walk_left  = walk_major + 2;
         walk_color = w.pixel_color;
         walk_busy  = 1'b1;
         lines_started++;
      end else if (walk_busy) begin
         point.point_x     = walk_x;
         point.point_y     = walk_y;
         point.point_color = walk_color;
         point.last_point  = (walk_left <= 1);
         expected_points.push_back(point);
         if (walk_left <= 1) begin
            walk_left = 0;
            walk_busy = 1'b0;
         end else begin
            walk_left--;
            walk_err_x += walk_dx;
            walk_err_y += walk_dy;
            if (walk_err_x > walk_major) begin
               walk_err_x -= walk_major;
               walk_x = step_coord(walk_x, walk_dir_x);
            end
            if (walk_err_y > walk_major) begin
               walk_err_y -= walk_major;
               walk_y = step_coord(walk_y, walk_dir_y);
            end
         end
      end
   endtask

   function automatic void check_value(input string field, input int expv, input int actv);
      if (expv != actv) begin
         $error("%s: expected %0d, actual %0d", field, expv, actv);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : point_checker
      lpg_pkg::rsp_type expected;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $error("point (%0d, %0d) with no point expected",
                   rsp_word.point_x, rsp_word.point_y);
            failures++;
         end else begin
            expected = expected_points.pop_front();
            check_value("point_x", int'(expected.point_x), int'(rsp_word.point_x));
            check_value("point_y", int'(expected.point_y), int'(rsp_word.point_y));
            check_value("point_color", int'(expected.point_color),
                        int'(rsp_word.point_color));
            check_value("last_point", int'(expected.last_point),
                        int'(rsp_word.last_point));
            points_checked++;
         end
      end
      rsp_stall <= (receiver_stall_pct != 0) && ($urandom_range(99) < receiver_stall_pct);
   end

   task automatic send_word(input lpg_pkg::req_type w);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      predict_word(w);
      words_sent++;
   endtask

   task automatic send_start(input int xs, input int ys, input int xe, input int ye,
                             input int color);
      lpg_pkg::req_type w;
      w.op          = lpg_pkg::OpStart;
      w.x_start     = lpg_pkg::coord_type'(xs);
      w.y_start     = lpg_pkg::coord_type'(ys);
      w.x_end       = lpg_pkg::coord_type'(xe);
      w.y_end       = lpg_pkg::coord_type'(ye);
      w.pixel_color = lpg_pkg::color_type'(color);
      send_word(w);
   endtask

   // payload of a next word is don't-care; randomize it
   task automatic send_next();
      lpg_pkg::req_type w;
      w.op          = lpg_pkg::OpNext;
      w.x_start     = lpg_pkg::coord_type'($urandom_range(MaxCoord));
      w.y_start     = lpg_pkg::coord_type'($urandom_range(MaxCoord));
      w.x_end       = lpg_pkg::coord_type'($urandom_range(MaxCoord));
      w.y_end       = lpg_pkg::coord_type'($urandom_range(MaxCoord));
      w.pixel_color = lpg_pkg::color_type'($urandom);
      send_word(w);
   endtask

   task automatic wait_for_points();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_points.size() != 0);
   endtask

   function automatic int pick_end(input int c, input int span);
      int v;
      if (span >= MaxCoord) return $urandom_range(MaxCoord);
      v = c + int'($urandom_range(2 * span)) - span;
      if (v < 0) v = 0;
      if (v > MaxCoord) v = MaxCoord;
      return v;
   endfunction

   task automatic test_next_while_idle();
      lpg_pkg::req_type w;
      w    = '1;
      w.op = lpg_pkg::OpNext;
      send_word(w);
      wait_for_points();
   endtask

   task automatic test_zero_length_line();
      send_start(MaxCoord, 0, MaxCoord, 0, 16'hFFFF);
      repeat (3) send_next();
      wait_for_points();
   endtask

   task automatic test_short_diagonal();
      send_start(MaxCoord, MaxCoord, MaxCoord - 3, MaxCoord - 1, 16'hA5A5);
      repeat (6) send_next();
      wait_for_points();
   endtask

   task automatic test_restart_while_busy();
      send_start(0, MaxCoord, 2, MaxCoord, 16'h0000);
      repeat (2) send_next();
      send_start(10, 20, 10, 17, 16'h1234);
      repeat (5) send_next();
      wait_for_points();
   endtask

   task automatic test_full_span_line();
      send_start(MaxCoord, 0, 0, MaxCoord, 16'h5A5A);
      repeat (64) send_next();
      wait_for_points();
   endtask

   task automatic test_random_lines(input int sender_pct, input int stall_pct,
                                    input int word_budget);
      lpg_pkg::req_type w;
      int               first_word;
      int               xs;
      int               ys;
      int               span;
      int               nexts;
      sender_idle_pct    = sender_pct;
      receiver_stall_pct = stall_pct;
      first_word         = words_sent;
      while (words_sent - first_word < word_budget) begin
         if ($urandom_range(9) == 0) begin
            w.op          = 1'($urandom_range(1));
            w.x_start     = lpg_pkg::coord_type'($urandom_range(MaxCoord));
            w.y_start     = lpg_pkg::coord_type'($urandom_range(MaxCoord));
            w.x_end       = lpg_pkg::coord_type'($urandom_range(MaxCoord));
            w.y_end       = lpg_pkg::coord_type'($urandom_range(MaxCoord));
            w.pixel_color = lpg_pkg::color_type'($urandom);
            send_word(w);
         end else begin
            xs = $urandom_range(MaxCoord);
            ys = $urandom_range(MaxCoord);
            case ($urandom_range(9))
               0:       span = 0;
               1, 2:    span = 1;
               3, 4, 5: span = 4;
               6, 7:    span = 16;
               8:       span = 64;
               default: span = MaxCoord;
            endcase
            send_start(xs, ys, pick_end(xs, span), pick_end(ys, span), $urandom);
            nexts = walk_left;
            case ($urandom_range(7))
               0:       nexts = $urandom_range(nexts);
               1:       nexts += $urandom_range(1, 3);
               default: ;
            endcase
            if (span == MaxCoord && nexts > 40) nexts = $urandom_range(1, 40);
            repeat (nexts) send_next();
            if ($urandom_range(19) == 0) wait_for_points();
         end
      end
      wait_for_points();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_next_while_idle();
      test_zero_length_line();
      test_short_diagonal();
      test_restart_while_busy();
      test_full_span_line();
      test_random_lines(0, 0, 440);
      test_random_lines(67, 0, 440);
      test_random_lines(0, 67, 440);
      test_random_lines(25, 25, 440);

      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      wait_for_points();
      repeat (20) @(posedge clock);

      $display("Sent %0d words over %0d lines, with and without sender gaps and stalls.",
               words_sent, lines_started);
      $display("Compared %0d points; %0d mismatches.", points_checked, failures);
      if (failures == 0 && expected_points.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timeout with %0d points outstanding", expected_points.size());
      $display("Verification failed");
      $finish;
   end

endmodule
